// ===== hdl/imhd_pkg.sv =====
// Package with the sizes, codes and entry types of the indexed min-heap core.
package imhd_pkg;
   localparam int CAPACITY    = 1024;
   localparam int VALUE_WIDTH = 16;
   localparam int KEY_SPACE   = 1024;
   localparam int KEY_W       = $clog2(KEY_SPACE);
   localparam int POS_W       = $clog2(CAPACITY);
   localparam int CNT_W       = POS_W + 1;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 3;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEC    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0]       key;
      logic [VALUE_WIDTH-1:0] value;
   } heap_entry_type;

   typedef struct packed {
      logic             present;
      logic [POS_W-1:0] pos;
   } kpos_entry_type;
endpackage

// ===== hdl/indexed_min_heap_decrement_core.sv =====
// Indexed binary min-heap with insert, decrement-by-one and pop-minimum.
//
// Usage: drive req_mode, req_item_key and req_item_value and raise start;
// the operation transfers at the rising edge where start is high and busy is
// low. Exactly one result comes back on rsp_status, rsp_out_key,
// rsp_out_value and rsp_count_after, marked by rsp_strobe for one cycle;
// the receiver takes it at the end of that cycle and cannot stall it.
// One operation is in flight at a time; busy drops in the cycle that its
// result is on the ports, so the next transfer can happen at that edge.
// Errors, no-ops and a pop of the last entry finish in the dispatch state.
// An insert climbs the tree one level per pass through S_UP and S_UP_CMP; a
// decrement first loads its entry in S_DEC_LOAD and then climbs likewise.
// A pop loads the last entry in S_POP_LOAD and descends, reading the left and
// right child of each level in turn from the single-read-port slot memory.
// The heap slots and the key-to-position map are two synchronous RAMs with a
// registered read; the moving entry is held in a register and written back
// once it settles.
// Reset: a synchronous reset clears the count and then sweeps the position
// map, one key per cycle, over all 1024 keys with busy high.
module indexed_min_heap_decrement_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [imhd_pkg::MODE_W-1:0]    req_mode,
   input  logic [imhd_pkg::KEY_W-1:0]     req_item_key,
   input  logic [imhd_pkg::VALUE_WIDTH-1:0] req_item_value,
   output logic                           rsp_strobe,
   output logic [imhd_pkg::STATUS_W-1:0]  rsp_status,
   output logic [imhd_pkg::KEY_W-1:0]     rsp_out_key,
   output logic [imhd_pkg::VALUE_WIDTH-1:0] rsp_out_value,
   output logic [imhd_pkg::CNT_W-1:0]     rsp_count_after
);
   import imhd_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_DEC_LOAD, S_POP_LOAD,
      S_UP, S_UP_CMP, S_DOWN, S_DOWN_L, S_DOWN_R, S_DOWN_CMP
   } state_type;

   heap_entry_type heap_mem [CAPACITY];
   kpos_entry_type kpos_mem [KEY_SPACE];

   state_type              state_ff, state_in;
   logic [KEY_W-1:0]       clr_ff, clr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   heap_entry_type         item_ff, item_in;
   heap_entry_type         child_ff, child_in;
   logic [POS_W-1:0]       at_ff, at_in;
   logic [POS_W-1:0]       par_ff, par_in;
   logic [POS_W-1:0]       pick_ff, pick_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]       rsp_key_ff, rsp_key_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]       rsp_count_ff;

   heap_entry_type         heap_rd_ff;
   kpos_entry_type         kpos_rd_ff;
   logic                   heap_we, kpos_we;
   logic [POS_W-1:0]       heap_wa, heap_ra;
   logic [KEY_W-1:0]       kpos_wa, kpos_ra;
   heap_entry_type         heap_wd;
   kpos_entry_type         kpos_wd;

   logic [CNT_W:0]         left_w, right_w, count_w;
   logic                   finish;

   assign left_w  = {1'b0, at_ff, 1'b1};
   assign right_w = left_w + 1'b1;
   assign count_w = {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[heap_wa] <= heap_wd;
      end
      heap_rd_ff <= heap_mem[heap_ra];
   end

   always_ff @(posedge clock) begin
      if (kpos_we) begin
         kpos_mem[kpos_wa] <= kpos_wd;
      end
      kpos_rd_ff <= kpos_mem[kpos_ra];
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      item_in       = item_ff;
      child_in      = child_ff;
      at_in         = at_ff;
      par_in        = par_ff;
      pick_in       = pick_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      finish        = 1'b0;
      heap_we       = 1'b0;
      heap_wa       = at_ff;
      heap_wd       = item_ff;
      heap_ra       = '0;
      kpos_we       = 1'b0;
      kpos_wa       = item_ff.key;
      kpos_wd       = '{present: 1'b1, pos: at_ff};
      kpos_ra       = req_item_key;

      unique case (state_ff)
         S_CLEAR: begin
            kpos_we = 1'b1;
            kpos_wa = clr_ff;
            kpos_wd = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == KEY_W'(KEY_SPACE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               mode_in       = req_mode;
               item_in       = '{key: req_item_key, value: req_item_value};
               rsp_status_in = ST_OK;
               rsp_key_in    = '0;
               rsp_value_in  = '0;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (mode_ff)
               MODE_INSERT: begin
                  if (kpos_rd_ff.present) begin
                     rsp_status_in = ST_DUP;
                     finish        = 1'b1;
                  end else if (count_ff >= CNT_W'(CAPACITY)) begin
                     rsp_status_in = ST_FULL;
                     finish        = 1'b1;
                  end else begin
                     at_in    = count_ff[POS_W-1:0];
                     count_in = count_ff + 1'b1;
                     state_in = S_UP;
                  end
               end
               MODE_DEC: begin
                  if (!kpos_rd_ff.present) begin
                     rsp_status_in = ST_ABSENT;
                     finish        = 1'b1;
                  end else if ({1'b0, kpos_rd_ff.pos} >= count_ff) begin
                     finish = 1'b1;
                  end else begin
                     at_in    = kpos_rd_ff.pos;
                     heap_ra  = kpos_rd_ff.pos;
                     state_in = S_DEC_LOAD;
                  end
               end
               MODE_POP: begin
                  if (count_ff == '0) begin
                     rsp_status_in = ST_EMPTY;
                     finish        = 1'b1;
                  end else begin
                     rsp_key_in   = heap_rd_ff.key;
                     rsp_value_in = heap_rd_ff.value;
                     kpos_we      = 1'b1;
                     kpos_wa      = heap_rd_ff.key;
                     kpos_wd      = '0;
                     count_in     = count_ff - 1'b1;
                     if (count_ff == CNT_W'(1)) begin
                        finish = 1'b1;
                     end else begin
                        heap_ra  = count_in[POS_W-1:0];
                        state_in = S_POP_LOAD;
                     end
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         S_DEC_LOAD: begin
            item_in.key   = heap_rd_ff.key;
            item_in.value = (heap_rd_ff.value == '0) ? '0 : heap_rd_ff.value - 1'b1;
            state_in      = S_UP;
         end
         S_POP_LOAD: begin
            item_in  = heap_rd_ff;
            at_in    = '0;
            state_in = S_DOWN;
         end
         S_UP: begin
            if (at_ff == '0) begin
               heap_we = 1'b1;
               kpos_we = 1'b1;
               finish  = 1'b1;
            end else begin
               par_in   = (at_ff - 1'b1) >> 1;
               heap_ra  = (at_ff - 1'b1) >> 1;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            heap_we = 1'b1;
            kpos_we = 1'b1;
            if (heap_rd_ff.value > item_ff.value) begin
               // The parent drops into the hole and the hole climbs.
               heap_wd  = heap_rd_ff;
               kpos_wa  = heap_rd_ff.key;
               at_in    = par_ff;
               state_in = S_UP;
            end else begin
               finish = 1'b1;
            end
         end
         S_DOWN: begin
            if (left_w >= count_w) begin
               heap_we = 1'b1;
               kpos_we = 1'b1;
               finish  = 1'b1;
            end else begin
               heap_ra  = left_w[POS_W-1:0];
               state_in = S_DOWN_L;
            end
         end
         S_DOWN_L: begin
            child_in = heap_rd_ff;
            pick_in  = left_w[POS_W-1:0];
            if (right_w < count_w) begin
               heap_ra  = right_w[POS_W-1:0];
               state_in = S_DOWN_R;
            end else begin
               state_in = S_DOWN_CMP;
            end
         end
         S_DOWN_R: begin
            if (heap_rd_ff.value < child_ff.value) begin
               child_in = heap_rd_ff;
               pick_in  = right_w[POS_W-1:0];
            end
            state_in = S_DOWN_CMP;
         end
         S_DOWN_CMP: begin
            heap_we = 1'b1;
            kpos_we = 1'b1;
            if (child_ff.value < item_ff.value) begin
               heap_wd  = child_ff;
               kpos_wa  = child_ff.key;
               at_in    = pick_ff;
               state_in = S_DOWN;
            end else begin
               finish = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in = S_IDLE;
      end
      rsp_strobe_in = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      mode_ff       <= mode_in;
      item_ff       <= item_in;
      child_ff      <= child_in;
      at_ff         <= at_in;
      par_ff        <= par_in;
      pick_ff       <= pick_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= count_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_count_after = rsp_count_ff;
endmodule

// ===== bench/indexed_min_heap_decrement_core_tb.sv =====
// Self-checking bench for the indexed min-heap core with a heap predictor.
module indexed_min_heap_decrement_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import imhd_pkg::*;

   typedef struct {
      logic [STATUS_W-1:0]    status;
      logic [KEY_W-1:0]       okey;
      logic [VALUE_WIDTH-1:0] oval;
      logic [CNT_W-1:0]       count;
   } heap_reply_type;

   // Heap predictor with its queue of expected replies.
   class heap_scoreboard;
      logic [KEY_W-1:0]       slot_key [CAPACITY];
      logic [VALUE_WIDTH-1:0] slot_val [CAPACITY];
      bit                     key_here [KEY_SPACE];
      int unsigned            key_slot [KEY_SPACE];
      int unsigned            count;
      heap_reply_type         pending [$];
      int                     mismatches;

      function void swap_slots(int unsigned a, int unsigned b);
         logic [KEY_W-1:0]       tk;
         logic [VALUE_WIDTH-1:0] tv;
         tk = slot_key[a]; tv = slot_val[a];
         slot_key[a] = slot_key[b]; slot_val[a] = slot_val[b];
         slot_key[b] = tk; slot_val[b] = tv;
         key_slot[slot_key[a]] = a;
         key_slot[slot_key[b]] = b;
      endfunction

      function void climb(int unsigned at);
         while (at > 0 && slot_val[(at - 1) / 2] > slot_val[at]) begin
            swap_slots(at, (at - 1) / 2);
            at = (at - 1) / 2;
         end
      endfunction

      function void descend();
         int unsigned at, pick;
         at = 0;
         forever begin
            if (2 * at + 1 >= count) break;
            pick = 2 * at + 1;
            if (pick + 1 < count && slot_val[pick + 1] < slot_val[pick]) pick = pick + 1;
            if (slot_val[pick] < slot_val[at]) begin
               swap_slots(at, pick);
               at = pick;
            end else break;
         end
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] k,
                                 logic [VALUE_WIDTH-1:0] v);
         heap_reply_type r;
         r.status = ST_OK; r.okey = '0; r.oval = '0;
         if (mode == MODE_INSERT) begin
            if (key_here[k]) r.status = ST_DUP;
            else if (count >= CAPACITY) r.status = ST_FULL;
            else begin
               slot_key[count] = k; slot_val[count] = v;
               key_here[k] = 1; key_slot[k] = count;
               count++;
               climb(count - 1);
            end
         end else if (mode == MODE_DEC) begin
            if (!key_here[k]) r.status = ST_ABSENT;
            else begin
               if (slot_val[key_slot[k]] > 0) slot_val[key_slot[k]]--;
               climb(key_slot[k]);
            end
         end else if (mode == MODE_POP) begin
            if (count == 0) r.status = ST_EMPTY;
            else begin
               r.okey = slot_key[0]; r.oval = slot_val[0];
               key_here[slot_key[0]] = 0;
               count--;
               if (count > 0) begin
                  slot_key[0] = slot_key[count]; slot_val[0] = slot_val[count];
                  key_slot[slot_key[0]] = 0;
                  descend();
               end
            end
         end
         r.count = CNT_W'(count);
         pending.push_back(r);
      endfunction

      function void check_reply(heap_reply_type got);
         heap_reply_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("reply with nothing outstanding");
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.okey !== want.okey ||
             got.oval !== want.oval || got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: want st=%0d k=%0d v=%0d n=%0d got st=%0d k=%0d v=%0d n=%0d",
                        want.status, want.okey, want.oval, want.count,
                        got.status, got.okey, got.oval, got.count);
         end
      endfunction
   endclass

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   start = 0;
   logic                   busy;
   logic [MODE_W-1:0]      req_mode = MODE_INSERT;
   logic [KEY_W-1:0]       req_item_key = '0;
   logic [VALUE_WIDTH-1:0] req_item_value = '0;
   logic                   rsp_strobe;
   logic [STATUS_W-1:0]    rsp_status;
   logic [KEY_W-1:0]       rsp_out_key;
   logic [VALUE_WIDTH-1:0] rsp_out_value;
   logic [CNT_W-1:0]       rsp_count_after;

   heap_scoreboard board = new();
   int idle_cycles;

   indexed_min_heap_decrement_core i_dut (.*);

   initial forever #1 clock = ~clock;

   // Track transfers on both sides and watch for a stuck block.
   always @(posedge clock) begin
      heap_reply_type got;
      bit moved;
      moved = 0;
      if (!reset) begin
         if (start && !busy) begin
            board.note_request(req_mode, req_item_key, req_item_value);
            moved = 1;
         end
         if (rsp_strobe) begin
            got.status = rsp_status; got.okey = rsp_out_key;
            got.oval = rsp_out_value; got.count = rsp_count_after;
            board.check_reply(got);
            moved = 1;
         end
         if (moved) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         // The limit leaves room for the reset sweep of the position map, which moves nothing.
         if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
         end
      end else idle_cycles <= 0;
   end

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
   endfunction

   // One operation; start stays high until the transfer happens, and on into
   // the next operation when no gap follows.
   task automatic send_op(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                          logic [VALUE_WIDTH-1:0] v, bit gaps);
      int n;
      req_mode <= m; req_item_key <= k; req_item_value <= v; start <= 1;
      do @(posedge clock); while (busy);
      n = gaps ? gap_length() : 0;
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // The first edge lets the monitor note the transfer that just happened.
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed part.
      send_op(MODE_POP, 10'd5, 16'd0, 0);                   // pop when empty
      send_op(MODE_DEC, 10'd7, 16'd0, 0);                   // absent key
      send_op(MODE_INSERT, 10'd1023, 16'hFFFF, 0);
      send_op(MODE_INSERT, 10'd0, 16'd0, 0);
      send_op(MODE_INSERT, 10'd0, 16'd9, 0);                // duplicate key
      send_op(MODE_DEC, 10'd0, 16'd0, 0);                   // saturates at zero
      send_op(MODE_INSERT, 10'd512, 16'd0, 0);              // tie with the root
      send_op(MODE_INSERT, 10'd341, 16'h8000, 0);
      send_op(MODE_DEC, 10'd341, 16'hFFFF, 0);
      send_op(MODE_NOP, 10'h3FF, 16'hFFFF, 0);              // mode three does nothing
      repeat (5) send_op(MODE_POP, 10'd0, 16'd0, 0);        // pops down past empty
      send_op(MODE_DEC, 10'd1023, 16'd0, 0);                // popped key is absent
      drain();
      // Random part: mostly inserts, decrements of keys from the insert range and pops.
      for (int i = 0; i < 734; i++) begin
         int sel;
         sel = $urandom_range(0, 99);
         if (sel < 40)
            send_op(MODE_INSERT, 10'($urandom_range(0, 63)),
                    ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 20))), 1);
         else if (sel < 70)
            send_op(MODE_DEC, 10'($urandom_range(0, 63)), 16'($urandom), 1);
         else if (sel < 95)
            send_op(MODE_POP, 10'($urandom), 16'($urandom), 1);
         else
            send_op(2'($urandom_range(0, 3)), 10'($urandom), 16'($urandom), 1);
         if (i == 400) drain();
      end
      drain();
      repeat (60) @(posedge clock);
      if (board.mismatches == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== sim.f =====
hdl/imhd_pkg.sv
hdl/indexed_min_heap_decrement_core.sv
bench/indexed_min_heap_decrement_core_tb.sv
